@@ hdl/hbf_pkg.sv @@
package hbf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 31;
    localparam int SQRT_STEPS    = 33;
    localparam int DIV_STEPS     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SPRING_K = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_Y   = 3'd4;

    typedef struct packed {
        logic [30:0] spring_k;
        logic [30:0] box_x;
        logic [30:0] box_y;
        logic        wrap_x;
        logic        wrap_y;
    } t_cfg;

    // per-bond data carried alongside the length computation
    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        sx;
        logic        sy;
        logic [30:0] r0;
        logic        inactive;
        logic        zero;
    } t_side;

    typedef struct packed {
        logic        valid;
        logic [64:0] sum;
        t_side       side;
    } t_sq;

    typedef struct packed {
        logic        valid;
        logic [32:0] r;
        t_side       side;
    } t_rt;

    typedef struct packed {
        logic        big;
        logic [32:0] rem;
        logic [31:0] lo;
        logic [31:0] q;
    } t_lane;

    typedef struct packed {
        logic        valid;
        logic [32:0] r;
        t_lane       x;
        t_lane       y;
        logic        neg_x;
        logic        neg_y;
        logic        inactive;
        logic        zero;
    } t_dv;

endpackage

@@ hdl/hbf_in_if.sv @@
interface hbf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_a_x;
    logic [31:0] pos_a_y;
    logic [31:0] pos_b_x;
    logic [31:0] pos_b_y;
    logic [30:0] rest_length;
    logic        inactive;

    modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, rest_length, inactive,
                    input ready);
    modport sink (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, rest_length, inactive,
                  output ready);
endinterface

@@ hdl/hbf_out_if.sv @@
interface hbf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic        skipped;
    logic        degenerate;
    logic        saturated;

    modport source (output valid, force_x, force_y, skipped, degenerate, saturated,
                    input ready);
    modport sink (input valid, force_x, force_y, skipped, degenerate, saturated,
                  output ready);
endinterface

@@ hdl/hbf_front.sv @@
module hbf_front import hbf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_cfg         i_cfg,
    hbf_in_if.sink       i_bond,
    output t_sq          o_sq
);

    typedef struct packed {
        logic               valid;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [30:0]        r0;
        logic               inactive;
    } t_dif;

    typedef struct packed {
        logic        valid;
        logic [63:0] qx;
        logic [63:0] qy;
        t_side       side;
    } t_sqr;

    t_dif r_s1, n_s1, r_s2, n_s2;
    t_sqr r_s3, n_s3;
    t_sq  r_s4, n_s4;

    // fold to the nearest periodic image
    function automatic logic signed [32:0] fold(logic signed [32:0] d, logic [30:0] box);
        logic [32:0]        m;
        logic signed [33:0] w;
        logic signed [33:0] nw;
        logic signed [32:0] res;
        m   = d[32] ? 33'(-d) : 33'(d);
        w   = $signed({3'b000, box}) - $signed({1'b0, m});
        nw  = -w;
        res = d;
        if (w < $signed({1'b0, m})) begin
            res = d[32] ? w[32:0] : nw[32:0];
        end
        return res;
    endfunction

    assign i_bond.ready = i_en;

    always_comb begin
        logic [31:0] ax;
        logic [31:0] ay;
        n_s1.valid    = i_bond.valid;
        n_s1.dx       = $signed({i_bond.pos_a_x[31], i_bond.pos_a_x})
                      - $signed({i_bond.pos_b_x[31], i_bond.pos_b_x});
        n_s1.dy       = $signed({i_bond.pos_a_y[31], i_bond.pos_a_y})
                      - $signed({i_bond.pos_b_y[31], i_bond.pos_b_y});
        n_s1.r0       = i_bond.rest_length;
        n_s1.inactive = i_bond.inactive;

        n_s2    = r_s1;
        if (i_cfg.wrap_x) begin
            n_s2.dx = fold(r_s1.dx, i_cfg.box_x);
        end
        if (i_cfg.wrap_y) begin
            n_s2.dy = fold(r_s1.dy, i_cfg.box_y);
        end

        ax = r_s2.dx[32] ? 32'(-r_s2.dx) : r_s2.dx[31:0];
        ay = r_s2.dy[32] ? 32'(-r_s2.dy) : r_s2.dy[31:0];
        n_s3.valid         = r_s2.valid;
        n_s3.qx            = ax * ax;
        n_s3.qy            = ay * ay;
        n_s3.side.ax       = ax;
        n_s3.side.ay       = ay;
        n_s3.side.sx       = r_s2.dx[32];
        n_s3.side.sy       = r_s2.dy[32];
        n_s3.side.r0       = r_s2.r0;
        n_s3.side.inactive = r_s2.inactive;
        n_s3.side.zero     = (r_s2.dx == 33'sd0) && (r_s2.dy == 33'sd0);

        n_s4.valid = r_s3.valid;
        n_s4.sum   = {1'b0, r_s3.qx} + {1'b0, r_s3.qy};
        n_s4.side  = r_s3.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_sq = r_s4;

endmodule

@@ hdl/hbf_sqrt.sv @@
module hbf_sqrt import hbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_sq  i_sq,
    output t_rt  o_rt
);

    typedef struct packed {
        logic        valid;
        logic [65:0] rad;
        logic [35:0] rem;
        logic [32:0] root;
        t_side       side;
    } t_sqs;

    t_sqs r_st [SQRT_STEPS];
    t_sqs n_st [SQRT_STEPS];
    t_sqs w_in;

    // one result bit per stage, top radicand pair first
    function automatic t_sqs sq_step(t_sqs s);
        logic [37:0] remt;
        logic [37:0] t;
        t_sqs        o;
        o    = s;
        remt = {s.rem, s.rad[65:64]};
        t    = {3'b000, s.root, 2'b01};
        o.rad = {s.rad[63:0], 2'b00};
        if (remt >= t) begin
            o.rem  = 36'(remt - t);
            o.root = {s.root[31:0], 1'b1};
        end else begin
            o.rem  = remt[35:0];
            o.root = {s.root[31:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        w_in.valid = i_sq.valid;
        w_in.rad   = {1'b0, i_sq.sum};
        w_in.rem   = '0;
        w_in.root  = '0;
        w_in.side  = i_sq.side;
        n_st[0]    = sq_step(w_in);
        for (int j = 1; j < SQRT_STEPS; j++) begin
            n_st[j] = sq_step(r_st[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQRT_STEPS; j++) begin
                r_st[j].valid <= 1'b0;
            end
        end else if (i_en) begin
            for (int j = 0; j < SQRT_STEPS; j++) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_rt.valid = r_st[SQRT_STEPS-1].valid;
    assign o_rt.r     = r_st[SQRT_STEPS-1].root;
    assign o_rt.side  = r_st[SQRT_STEPS-1].side;

endmodule

@@ hdl/hbf_scale.sv @@
module hbf_scale import hbf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [30:0] i_spring_k,
    input  t_rt         i_rt,
    output t_dv         o_dv
);

    localparam int NW = 96 - FRAC_BITS;
    localparam int TW = NW - 32;

    typedef struct packed {
        logic        valid;
        logic [32:0] r;
        logic [32:0] absdr;
        logic        negdr;
        logic [63:0] kdr;
        logic [63:0] plo_x;
        logic [63:0] phi_x;
        logic [63:0] plo_y;
        logic [63:0] phi_y;
        t_side       side;
    } t_sc;

    t_sc            r_k1, n_k1, r_k2, n_k2, r_k3, n_k3, r_k4;
    logic [NW-1:0]  r_nx, r_ny, n_nx, n_ny;
    t_dv            r_k5, n_k5;

    always_comb begin
        logic signed [33:0] dr;
        logic [95:0]        sx;
        logic [95:0]        sy;
        logic [TW-1:0]      tx;
        logic [TW-1:0]      ty;

        dr          = $signed({1'b0, i_rt.r}) - $signed({3'b000, i_rt.side.r0});
        n_k1        = '0;
        n_k1.valid  = i_rt.valid;
        n_k1.r      = i_rt.r;
        n_k1.negdr  = dr[33];
        n_k1.absdr  = dr[33] ? 33'(-dr) : dr[32:0];
        n_k1.side   = i_rt.side;

        n_k2        = r_k1;
        n_k2.kdr    = i_spring_k * r_k1.absdr;

        n_k3        = r_k2;
        n_k3.plo_x  = r_k2.kdr[31:0]  * r_k2.side.ax;
        n_k3.phi_x  = r_k2.kdr[63:32] * r_k2.side.ax;
        n_k3.plo_y  = r_k2.kdr[31:0]  * r_k2.side.ay;
        n_k3.phi_y  = r_k2.kdr[63:32] * r_k2.side.ay;

        sx   = {32'b0, r_k3.plo_x} + {r_k3.phi_x, 32'b0};
        sy   = {32'b0, r_k3.plo_y} + {r_k3.phi_y, 32'b0};
        n_nx = sx[95:FRAC_BITS];
        n_ny = sy[95:FRAC_BITS];

        // a quotient that needs more than 32 bits is flagged up front
        tx = r_nx[NW-1:32];
        ty = r_ny[NW-1:32];
        n_k5.valid    = r_k4.valid;
        n_k5.r        = r_k4.r;
        n_k5.x.big    = tx >= TW'(r_k4.r);
        n_k5.x.rem    = tx[32:0];
        n_k5.x.lo     = r_nx[31:0];
        n_k5.x.q      = '0;
        n_k5.y.big    = ty >= TW'(r_k4.r);
        n_k5.y.rem    = ty[32:0];
        n_k5.y.lo     = r_ny[31:0];
        n_k5.y.q      = '0;
        n_k5.neg_x    = r_k4.negdr ^ r_k4.side.sx;
        n_k5.neg_y    = r_k4.negdr ^ r_k4.side.sy;
        n_k5.inactive = r_k4.side.inactive;
        n_k5.zero     = r_k4.side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1.valid <= 1'b0;
            r_k2.valid <= 1'b0;
            r_k3.valid <= 1'b0;
            r_k4.valid <= 1'b0;
            r_k5.valid <= 1'b0;
        end else if (i_en) begin
            r_k1 <= n_k1;
            r_k2 <= n_k2;
            r_k3 <= n_k3;
            r_k4 <= r_k3;
            r_nx <= n_nx;
            r_ny <= n_ny;
            r_k5 <= n_k5;
        end
    end

    assign o_dv = r_k5;

endmodule

@@ hdl/hbf_div.sv @@
module hbf_div import hbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_dv  i_dv,
    output t_dv  o_dv
);

    t_dv r_st [DIV_STEPS];
    t_dv n_st [DIV_STEPS];

    // one restoring step: one quotient bit per lane
    function automatic t_lane div_step(t_lane l, logic [32:0] r);
        logic [33:0] remt;
        t_lane       o;
        o    = l;
        remt = {l.rem, l.lo[31]};
        o.lo = {l.lo[30:0], 1'b0};
        if (remt >= {1'b0, r}) begin
            o.rem = 33'(remt - {1'b0, r});
            o.q   = {l.q[30:0], 1'b1};
        end else begin
            o.rem = remt[32:0];
            o.q   = {l.q[30:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_st[0]   = i_dv;
        n_st[0].x = div_step(i_dv.x, i_dv.r);
        n_st[0].y = div_step(i_dv.y, i_dv.r);
        for (int j = 1; j < DIV_STEPS; j++) begin
            n_st[j]   = r_st[j-1];
            n_st[j].x = div_step(r_st[j-1].x, r_st[j-1].r);
            n_st[j].y = div_step(r_st[j-1].y, r_st[j-1].r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_st[j].valid <= 1'b0;
            end
        end else if (i_en) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_dv = r_st[DIV_STEPS-1];

endmodule

@@ hdl/harmonic_bond_force_2d.sv @@
// Channel   Dir  Modport  Beat contents
// i_bond    in   sink     pos_a_x/y, pos_b_x/y, rest_length, inactive
// o_force   out  source   force_x/y, skipped, degenerate, saturated
// i_cfg_*   in   -        write enable, register index, data (no handshake)
//
// One bond per cycle sustained while the skid is empty; each beat passes
// through 4 geometry stages, 33 square-root stages, 5 scaling stages, 32
// divider stages and the output register. The divider and square root
// produce one bit per stage, which sets the depth.
// Reset is synchronous, active low; it clears valid bits and loads the
// configuration defaults (spring constant 1.0, no boxes, no wrap).
// A stall holds the whole pipe only once the skid register behind the
// output register is full; until then input beats keep flowing.
module harmonic_bond_force_2d import hbf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    hbf_in_if.sink                i_bond,
    hbf_out_if.source             o_force
);

    typedef struct packed {
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic        skipped;
        logic        degenerate;
        logic        saturated;
    } t_res;

    t_cfg  r_cfg;
    t_sq   w_sq;
    t_rt   w_rt;
    t_dv   w_dv_in, w_dv;
    t_res  n_res, r_out, r_skid;
    logic  r_out_v, r_skid_v;
    logic  w_en, w_take;

    function automatic logic [32:0] clamp(t_lane l, logic neg);
        logic [31:0] v;
        logic        sat;
        sat = 1'b0;
        if (neg) begin
            if (l.big || l.q > 32'h8000_0000) begin
                v   = 32'h8000_0000;
                sat = 1'b1;
            end else begin
                v = 32'(-l.q);
            end
        end else begin
            if (l.big || l.q[31]) begin
                v   = 32'h7FFF_FFFF;
                sat = 1'b1;
            end else begin
                v = l.q;
            end
        end
        return {sat, v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spring_k <= 31'(1) << FRAC_BITS;
            r_cfg.box_x    <= '0;
            r_cfg.box_y    <= '0;
            r_cfg.wrap_x   <= 1'b0;
            r_cfg.wrap_y   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPRING_K: r_cfg.spring_k <= i_cfg_wdata;
                REG_BOX_X:    r_cfg.box_x    <= i_cfg_wdata;
                REG_BOX_Y:    r_cfg.box_y    <= i_cfg_wdata;
                REG_WRAP_X:   r_cfg.wrap_x   <= i_cfg_wdata[0];
                REG_WRAP_Y:   r_cfg.wrap_y   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_en   = !r_skid_v;
    assign w_take = r_out_v && o_force.ready;

    hbf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_bond  (i_bond),
        .o_sq    (w_sq)
    );

    hbf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_sq    (w_sq),
        .o_rt    (w_rt)
    );

    hbf_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_spring_k (r_cfg.spring_k),
        .i_rt       (w_rt),
        .o_dv       (w_dv_in)
    );

    hbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_dv    (w_dv_in),
        .o_dv    (w_dv)
    );

    always_comb begin
        logic [32:0] cx;
        logic [32:0] cy;
        cx = clamp(w_dv.x, w_dv.neg_x);
        cy = clamp(w_dv.y, w_dv.neg_y);
        n_res.skipped    = w_dv.inactive;
        n_res.degenerate = !w_dv.inactive && w_dv.zero;
        if (w_dv.inactive || w_dv.zero) begin
            n_res.force_x   = '0;
            n_res.force_y   = '0;
            n_res.saturated = 1'b0;
        end else begin
            n_res.force_x   = cx[31:0];
            n_res.force_y   = cy[31:0];
            n_res.saturated = cx[32] | cy[32];
        end
    end

    // output register plus skid: park a beat while the sink holds off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (w_dv.valid) begin
            if (!r_out_v || w_take) begin
                r_out   <= n_res;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= n_res;
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_force.valid      = r_out_v;
    assign o_force.force_x    = r_out.force_x;
    assign o_force.force_y    = r_out.force_y;
    assign o_force.skipped    = r_out.skipped;
    assign o_force.degenerate = r_out.degenerate;
    assign o_force.saturated  = r_out.saturated;

endmodule

@@ tb/tb_top.sv @@
module tb_top import hbf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic        skipped;
        logic        degenerate;
        logic        saturated;
    } t_force;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_SPRING_K;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    hbf_in_if i_bond();
    hbf_out_if o_force();

    harmonic_bond_force_2d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .i_bond(i_bond.sink), .o_force(o_force.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the registers
    logic [30:0] k_reg = 31'h10000;
    logic [30:0] box_x = '0, box_y = '0;
    logic        wrp_x = 1'b0, wrp_y = 1'b0;

    t_force force_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit idle_on = 1'b1;
    int hold_off = 0;
    int rx_idle = 0;

    initial begin
        i_bond.valid = 1'b0;
        i_bond.pos_a_x = '0; i_bond.pos_a_y = '0;
        i_bond.pos_b_x = '0; i_bond.pos_b_y = '0;
        i_bond.rest_length = '0; i_bond.inactive = 1'b0;
        o_force.ready = 1'b0;
    end

    function automatic logic signed [33:0] fold_axis(logic signed [33:0] d, logic [30:0] box);
        logic signed [33:0] m, w;
        m = d < 0 ? -d : d;
        w = $signed({3'b0, box}) - m;
        if (w < m) return d > 0 ? -w : w;
        return d;
    endfunction

    function automatic logic [32:0] root66(logic [65:0] v);
        logic [67:0] rem;
        logic [34:0] rt, t;
        rem = '0; rt = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | v[2*i +: 2];
            t = (rt << 2) | 1;
            if (rem >= t) begin
                rem = rem - t;
                rt = (rt << 1) | 1;
            end else begin
                rt = rt << 1;
            end
        end
        return rt[32:0];
    endfunction

    // one scaled component, clamped to 32 bits
    function automatic logic [31:0] scale_axis(logic [63:0] kdr, logic neg_dr,
                                               logic signed [33:0] d, logic [63:0] denom,
                                               ref logic sat);
        logic [127:0] q;
        logic [33:0] mag;
        logic neg;
        mag = d < 0 ? -d : d;
        neg = neg_dr ^ (d < 0);
        if (d == 0 || kdr == 0) return '0;
        q = (128'(kdr) * 128'(mag)) / 128'(denom);
        if (neg) begin
            if (q > 128'h80000000) begin q = 128'h80000000; sat = 1'b1; end
            return -q[31:0];
        end
        if (q > 128'h7fffffff) begin q = 128'h7fffffff; sat = 1'b1; end
        return q[31:0];
    endfunction

    function automatic t_force bond_force(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                                          logic [31:0] by, logic [30:0] r0, logic inact);
        t_force f;
        logic signed [33:0] dx, dy, dr;
        logic [33:0] mx, my;
        logic [32:0] r;
        logic [63:0] kdr;
        logic sat;
        f = '{default: '0};
        sat = 1'b0;
        if (inact) begin
            f.skipped = 1'b1;
            return f;
        end
        dx = $signed(ax) - $signed(bx);
        dy = $signed(ay) - $signed(by);
        if (wrp_x) dx = fold_axis(dx, box_x);
        if (wrp_y) dy = fold_axis(dy, box_y);
        if (dx == 0 && dy == 0) begin
            f.degenerate = 1'b1;
            return f;
        end
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        r = root66(66'(mx) * 66'(mx) + 66'(my) * 66'(my));
        dr = $signed({1'b0, r}) - $signed({3'b0, r0});
        kdr = 64'(k_reg) * 64'(dr < 0 ? -dr : dr);
        f.fx = scale_axis(kdr, dr < 0, dx, 64'(r) << 16, sat);
        f.fy = scale_axis(kdr, dr < 0, dy, 64'(r) << 16, sat);
        f.saturated = sat;
        return f;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SPRING_K: k_reg = val;
            REG_BOX_X: box_x = val;
            REG_BOX_Y: box_y = val;
            REG_WRAP_X: wrp_x = val[0];
            REG_WRAP_Y: wrp_y = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_bond(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                             logic [31:0] by, logic [30:0] r0, logic inact);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_bond.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_bond.valid <= 1'b1;
        i_bond.pos_a_x <= ax; i_bond.pos_a_y <= ay;
        i_bond.pos_b_x <= bx; i_bond.pos_b_y <= by;
        i_bond.rest_length <= r0; i_bond.inactive <= inact;
        do @(posedge i_clk); while (!i_bond.ready);
        force_q.push_back(bond_force(ax, ay, bx, by, r0, inact));
    endtask

    task automatic stop_sending();
        i_bond.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 400000)) - 200000);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
        endcase
    endfunction

    task automatic random_bond();
        logic [31:0] ax, ay;
        logic [30:0] r0;
        ax = rnd_pos();
        ay = rnd_pos();
        r0 = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 2000000));
        if ($urandom_range(0, 15) == 0)
            send_bond(ax, ay, ax, ay, r0, 1'b0);
        else
            send_bond(ax, ay, rnd_pos(), rnd_pos(), r0, $urandom_range(0, 9) == 0);
    endtask

    task automatic test_extremes();
        send_bond('0, '0, '0, '0, '0, 1'b0);
        send_bond(32'h10000, '0, '0, '0, '0, 1'b1);
        send_bond(32'h10000, '0, '0, '0, 31'h8000, 1'b0);
        send_bond('0, 32'h30000, '0, '0, 31'h7fffffff, 1'b0);
        send_bond(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, '0, 1'b0);
        send_bond(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 1'b0);
        send_bond(32'hffffffff, 32'h1, 32'h1, 32'hffffffff, 31'h1, 1'b0);
        send_bond('1, '1, '1, '1, '1, 1'b1);
        send_bond(32'h12345, 32'h12345, 32'h12345, 32'h12345, 31'h5555, 1'b0);
        stop_sending();
        drain();
    endtask

    task automatic test_stiff_spring();
        cfg_write(REG_SPRING_K, 31'h7fffffff);
        send_bond(32'h10000, 32'h0, '0, '0, '0, 1'b0);
        send_bond(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, '0, 1'b0);
        send_bond(32'h1, '0, '0, '0, 31'h7fffffff, 1'b0);
        repeat (60) random_bond();
        stop_sending();
        drain();
        cfg_write(REG_SPRING_K, '0);
        send_bond(32'h50000, 32'h10, '0, '0, 31'h100, 1'b0);
        repeat (30) random_bond();
        stop_sending();
        drain();
    endtask

    task automatic test_wrap();
        cfg_write(REG_SPRING_K, 31'h28000);
        cfg_write(REG_BOX_X, 31'h100000);
        cfg_write(REG_BOX_Y, 31'h80000);
        cfg_write(REG_WRAP_X, 1'b1);
        cfg_write(REG_WRAP_Y, 1'b1);
        send_bond(32'h100000, '0, '0, '0, '0, 1'b0);
        send_bond(32'hf0000, 32'h70000, '0, '0, '0, 1'b0);
        send_bond(32'h80000, 32'h40000, '0, '0, 31'h1000, 1'b0);
        repeat (120) random_bond();
        stop_sending();
        drain();
        cfg_write(REG_BOX_X, '0);
        cfg_write(REG_BOX_Y, 31'h7fffffff);
        repeat (80) random_bond();
        stop_sending();
        drain();
        cfg_write(REG_WRAP_X, 1'b0);
        cfg_write(REG_BOX_Y, 31'h3);
        repeat (80) random_bond();
        stop_sending();
        drain();
        cfg_write(REG_WRAP_Y, 1'b0);
        cfg_write(REG_SPRING_K, 31'h10000);
    endtask

    // long receiver hold-off while the bond side keeps offering beats
    task automatic test_backpressure();
        hold_off = 400;
        repeat (150) random_bond();
        stop_sending();
        drain();
    endtask

    task automatic test_random_stream();
        repeat (200) random_bond();
        idle_on = 1'b0;
        repeat (60) random_bond();
        stop_sending();
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_stiff_spring();
        test_wrap();
        test_backpressure();
        test_random_stream();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver drops ready during hold_off, in reset and in random idle bursts
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            o_force.ready <= 1'b0;
        end else if (!i_rst_n) begin
            o_force.ready <= 1'b0;
        end else if (rx_idle > 0) begin
            rx_idle <= rx_idle - 1;
            o_force.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_idle <= $urandom_range(0, 11);
            o_force.ready <= 1'b0;
        end else begin
            o_force.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_force e;
        if (i_rst_n && o_force.valid && o_force.ready) begin
            if (force_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected force beat");
            end else begin
                e = force_q.pop_front();
                if (o_force.force_x !== e.fx || o_force.force_y !== e.fy ||
                    o_force.skipped !== e.skipped || o_force.degenerate !== e.degenerate ||
                    o_force.saturated !== e.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("force mismatch: exp %h %h s%b d%b t%b, got %h %h s%b d%b t%b",
                                 e.fx, e.fy, e.skipped, e.degenerate, e.saturated,
                                 o_force.force_x, o_force.force_y, o_force.skipped,
                                 o_force.degenerate, o_force.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end
endmodule
